// ----- design/cnfq_pkg.sv -----
// Package for the CRC-4 nibble frame queue.
// Holds the opcode codes, field widths and the CRC-4 framing function.
// No dependencies.
package cnfq_pkg;

  localparam int OPCODE_W = 2;
  localparam int NIBBLE_W = 4;
  localparam int BYTE_W   = 8;

  // Item opcodes
  localparam logic [OPCODE_W-1:0] OP_ENQUEUE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_SEND    = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_RX      = 2'd2;

  localparam logic [NIBBLE_W-1:0] CRC4_GEN = 4'b1101;

  // Status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // CRC-4, data fed MSB first, reflected shift-right form
  function automatic logic [NIBBLE_W-1:0] crc4_of(input logic [NIBBLE_W-1:0] nib);
    logic [NIBBLE_W-1:0] crc;
    crc = '0;
    for (int i = NIBBLE_W - 1; i >= 0; i--) begin
      crc[0] = crc[0] ^ nib[i];
      if (crc[0]) begin
        crc = crc ^ CRC4_GEN;
      end
      crc = crc >> 1;
    end
    return crc;
  endfunction

  // Data nibble in the high half, CRC in the low half
  function automatic logic [BYTE_W-1:0] frame_of(input logic [NIBBLE_W-1:0] nib);
    return {nib, crc4_of(nib)};
  endfunction

endpackage

// ----- design/cnfq_if.sv -----
// Valid/ready channel interfaces for the frame queue request and response.
// Depends on cnfq_pkg for field widths.
interface cnfq_req_if import cnfq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [NIBBLE_W-1:0] raw_nibble;
  logic [BYTE_W-1:0]   received_byte;

  modport source (output valid, opcode, raw_nibble, received_byte, input ready);
  modport sink   (input valid, opcode, raw_nibble, received_byte, output ready);
endinterface

interface cnfq_rsp_if import cnfq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                status;
  logic [BYTE_W-1:0]   tx_byte;
  logic [NIBBLE_W-1:0] command_nibble;
  logic                command_valid;

  modport source (output valid, status, tx_byte, command_nibble, command_valid,
                  input ready);
  modport sink   (input valid, status, tx_byte, command_nibble, command_valid,
                  output ready);
endinterface

// ----- design/cnfq_ring.sv -----
// Frame ring storage: one write port, one read port, registered read data.
// Per-entry valid bits make unwritten slots read as zero after reset.
// Depends on cnfq_pkg.
module cnfq_ring import cnfq_pkg::*; #(
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld;
  logic [BYTE_W-1:0] rd_q;
  logic              rd_vld;

  // Storage array, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Written marks and read-side valid
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

// ----- design/crc4_nibble_frame_queue_top.sv -----
// Enqueue and receive-check results are registered on the transfer; a send
// poll reads the ring first, then registers its result in ST_POP. Throughput:
// one item per cycle while the output is not stalled, except a send poll,
// which holds off the next item while the ring slot is read and cleared.
// Reset clears both indices, the ring's written marks and the output valid bit;
// the ring reads as all zeros immediately after reset, with no clearing pass.
module crc4_nibble_frame_queue_top import cnfq_pkg::*; #(
  parameter int RING_DEPTH = 8
) (
  input logic        clk,
  input logic        rst,
  cnfq_req_if.sink   req,
  cnfq_rsp_if.source rsp
);

  localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_POP  = 1'b1;

  logic             state;
  logic [IDX_W-1:0] write_index;
  logic [IDX_W-1:0] read_index;

  logic                out_valid;
  logic                out_status;
  logic [BYTE_W-1:0]   out_tx;
  logic [NIBBLE_W-1:0] out_cmd;
  logic                out_cmd_valid;

  logic              accept;
  logic              pop_ok;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic              rd_en;
  logic [BYTE_W-1:0] rd_data;
  logic [NIBBLE_W-1:0] rx_hi;
  logic              rx_match;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  // Input side: take an item when idle and the output slot is free or draining
  assign req.ready = (state == ST_IDLE) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  // Ring access
  assign rd_en  = accept && (req.opcode == OP_SEND);
  assign pop_ok = (state == ST_POP) && (read_index != write_index) && (rd_data != '0);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = write_index;
    wr_data = frame_of(req.raw_nibble);
    if (accept && (req.opcode == OP_ENQUEUE)) begin
      wr_en = 1'b1;
    end else if (pop_ok) begin
      wr_en   = 1'b1;
      wr_addr = read_index;
      wr_data = '0;
    end
  end

  cnfq_ring #(
    .DEPTH  (RING_DEPTH),
    .ADDR_W (IDX_W)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (read_index),
    .rd_data (rd_data)
  );

  // Receive-side CRC check
  assign rx_hi    = req.received_byte[BYTE_W-1:NIBBLE_W];
  assign rx_match = (req.received_byte[NIBBLE_W-1:0] == crc4_of(rx_hi));

  // Control: state, indices, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      write_index <= '0;
      read_index  <= '0;
      out_valid   <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          // new result replaces a draining one; otherwise drain on ready
          if (accept && (req.opcode != OP_SEND)) begin
            out_valid <= 1'b1;
          end else if (rsp.ready) begin
            out_valid <= 1'b0;
          end
          if (accept) begin
            if (req.opcode == OP_SEND) begin
              state <= ST_POP;
            end
            if (req.opcode == OP_ENQUEUE) begin
              write_index <= next_idx(write_index);
            end
          end
        end
        ST_POP: begin
          state     <= ST_IDLE;
          out_valid <= 1'b1;
          if (pop_ok) begin
            read_index <= next_idx(read_index);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (state == ST_POP) begin
      out_status    <= pop_ok ? STATUS_OK : STATUS_ERR;
      out_tx        <= pop_ok ? rd_data : '0;
      out_cmd       <= '0;
      out_cmd_valid <= 1'b0;
    end else if (accept) begin
      out_tx        <= '0;
      out_cmd       <= '0;
      out_cmd_valid <= 1'b0;
      unique case (req.opcode)
        OP_ENQUEUE: out_status <= STATUS_OK;
        OP_RX: begin
          if (req.received_byte != '0) begin
            out_status    <= STATUS_OK;
            out_cmd       <= rx_match ? rx_hi : '0;
            out_cmd_valid <= rx_match;
          end else begin
            out_status <= STATUS_ERR;
          end
        end
        default: out_status <= STATUS_ERR;
      endcase
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.tx_byte        = out_tx;
  assign rsp.command_nibble = out_cmd;
  assign rsp.command_valid  = out_cmd_valid;

endmodule

// ----- design/cnfq_checker.sv -----
// Port-level checker for the frame queue, attached to the top level by bind.
// Depends on cnfq_pkg for field widths.
module cnfq_checker import cnfq_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic                status,
  input logic [BYTE_W-1:0]   tx_byte,
  input logic [NIBBLE_W-1:0] command_nibble,
  input logic                command_valid
);

  // A delivered command always reports ok and carries no transmit byte
  a_cmd_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && command_valid |-> (status == STATUS_OK) && (tx_byte == '0))
    else $error("command delivered with bad status or tx byte");

  // A popped byte always reports ok and carries no command
  a_tx_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (tx_byte != '0) |-> (status == STATUS_OK) && !command_valid)
    else $error("tx byte with bad status or command");

  // Command nibble is zero unless the frame check passed
  a_cmd_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !command_valid |-> (command_nibble == '0))
    else $error("command nibble without command valid");

  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(tx_byte)
      && $stable(command_nibble) && $stable(command_valid))
    else $error("result changed while stalled");

endmodule

bind crc4_nibble_frame_queue_top cnfq_checker u_cnfq_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .status         (rsp.status),
  .tx_byte        (rsp.tx_byte),
  .command_nibble (rsp.command_nibble),
  .command_valid  (rsp.command_valid)
);
